// ----- rtl/prl_pkg.sv -----
// prl_pkg: shared types and codes for the positional record list.
// Used by prl_cell, prl_match and positional_record_list.
`timescale 1ns / 1ps

package prl_pkg;

  localparam int unsigned DEF_CAPACITY   = 64;
  localparam int unsigned DEF_NAME_BYTES = 20;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_cmd_e;

  typedef struct packed {
    logic [31:0]        mark;
    logic signed [31:0] id;
    logic [31:0]        name2;
    logic [63:0]        name1;
    logic [63:0]        name0;
  } record_t;

  typedef struct packed {
    cell_cmd_e cmd;
    record_t   wr_rec;
  } cell_ctrl_t;

endpackage

// ----- rtl/positional_record_list.sv -----
// positional_record_list: ordered list of fixed-size records kept in a row
// of cells. Depends on prl_pkg, prl_cell and prl_match.
`timescale 1ns / 1ps

// Usage:
//   Requests enter on the s_axis channel: tuser carries the operation
//   (insert, delete, search by name, read at position), tdata the position,
//   name words, id and mark bits. Each request yields exactly one word on
//   the m_axis channel: tuser carries the status, tdata the found index,
//   entry count after the operation and the found or read record.
//   One request is in work at a time; s_axis_tready is high only when idle.
//   Insert and delete shift every cell at once in the execute state, then
//   the result word is formed in the finish state.
//   Search and read rotate the whole cell row once past a single name
//   compare unit at cell 0 in the scan state, then go to the finish state.
//   The result sits in an output register; a new request is accepted while
//   it waits. If the receiver stalls, the block holds the next result until
//   the output register frees up.
//   Reset clears the entry count and the control state; record storage is
//   left as is and only entries below the count are ever reported.
//   No clearing pass follows reset.

module positional_record_list #(
  parameter int unsigned CAPACITY   = prl_pkg::DEF_CAPACITY,
  parameter int unsigned NAME_BYTES = prl_pkg::DEF_NAME_BYTES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // position[6:0], name_word0[70:7], name_word1[134:71], name_word2[166:135],
  // student_id[198:167], mark_bits[230:199], zero pad[231]
  input  logic [231:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // found_index[5:0], entry_total[12:6], out_name_word0[76:13],
  // out_name_word1[140:77], out_name_word2[172:141], out_id[204:173],
  // out_mark_bits[236:205], zero pad[239:237]
  output logic [239:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]   m_axis_tuser
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned POS_W = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [CNT_W-1:0] CountFull = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] ScanLast  = IDX_W'(CAPACITY - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]          state_q, state_d;
  prl_pkg::op_e        op_q;
  logic [POS_W-1:0]    pos_q;
  prl_pkg::record_t    key_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    scan_q, scan_d;
  logic                hit_q, hit_d;
  logic [IDX_W-1:0]    hit_idx_q, hit_idx_d;
  prl_pkg::record_t    cap_q, cap_d;
  prl_pkg::status_e    res_status_q, res_status_d;

  logic                out_valid_q, out_valid_d;
  logic [239:0]        out_data_q;
  logic [1:0]          out_user_q;

  prl_pkg::cell_ctrl_t ctrl;
  prl_pkg::record_t    cell_rec [CAPACITY];
  logic                head_match;

  logic                in_fire;
  logic                out_free;
  logic                read_bad;
  logic [POS_W-1:0]    count_pos;
  prl_pkg::status_e    fin_status;
  logic [5:0]          fin_idx;
  prl_pkg::record_t    fin_rec;

  assign in_fire   = s_axis_tvalid & s_axis_tready;
  assign out_free  = ~out_valid_q | m_axis_tready;
  assign count_pos = POS_W'(count_q);
  assign read_bad  = (count_q == '0) || (pos_q >= count_pos);

  // cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    prl_pkg::record_t left_rec, right_rec;
    if (g == 0) begin : g_first
      assign left_rec = key_q;
    end else begin : g_mid_l
      assign left_rec = cell_rec[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_rec = cell_rec[0];
    end else begin : g_mid_r
      assign right_rec = cell_rec[g+1];
    end
    prl_cell #(
      .INDEX (g),
      .POS_W (POS_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (pos_q),
      .left_i  (left_rec),
      .right_i (right_rec),
      .rec_o   (cell_rec[g])
    );
  end

  prl_match #(
    .NAME_BYTES (NAME_BYTES)
  ) u_match (
    .stored_i (cell_rec[0]),
    .key_i    (key_q),
    .match_o  (head_match)
  );

  // control
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    scan_d       = scan_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    cap_d        = cap_q;
    res_status_d = res_status_q;
    ctrl.cmd     = prl_pkg::CELL_HOLD;
    ctrl.wr_rec  = key_q;
    out_valid_d  = out_valid_q & ~m_axis_tready;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        scan_d       = '0;
        hit_d        = 1'b0;
        res_status_d = prl_pkg::ST_OK;
        state_d      = ST_FIN;
        unique case (op_q)
          prl_pkg::OP_INSERT: begin
            if (count_q == CountFull) begin
              res_status_d = prl_pkg::ST_FULL;
            end else if (pos_q > count_pos) begin
              res_status_d = prl_pkg::ST_BAD_POS;
            end else begin
              ctrl.cmd = prl_pkg::CELL_INSERT;
              count_d  = count_q + CNT_W'(1);
            end
          end
          prl_pkg::OP_DELETE: begin
            if (read_bad) begin
              res_status_d = prl_pkg::ST_BAD_POS;
            end else begin
              ctrl.cmd = prl_pkg::CELL_DELETE;
              count_d  = count_q - CNT_W'(1);
            end
          end
          default: state_d = ST_SCAN;
        endcase
      end
      ST_SCAN: begin
        // cell 0 holds original entry scan_q this cycle
        ctrl.cmd = prl_pkg::CELL_ROTATE;
        if (op_q == prl_pkg::OP_SEARCH) begin
          if (head_match && (CNT_W'(scan_q) < count_q)) begin
            hit_d     = 1'b1;
            hit_idx_d = scan_q;
            cap_d     = cell_rec[0];
          end
        end else if (POS_W'(scan_q) == pos_q) begin
          cap_d = cell_rec[0];
        end
        scan_d = scan_q + IDX_W'(1);
        if (scan_q == ScanLast) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result formatting
  always_comb begin
    fin_idx = 6'(pos_q);
    unique case (op_q)
      prl_pkg::OP_SEARCH: begin
        fin_status = hit_q ? prl_pkg::ST_OK : prl_pkg::ST_NOT_FOUND;
        fin_idx    = hit_q ? 6'(hit_idx_q) : 6'd0;
      end
      prl_pkg::OP_READ: fin_status = read_bad ? prl_pkg::ST_BAD_POS : prl_pkg::ST_OK;
      default:          fin_status = res_status_q;
    endcase
    fin_rec = '0;
    if ((fin_status == prl_pkg::ST_OK) &&
        ((op_q == prl_pkg::OP_SEARCH) || (op_q == prl_pkg::OP_READ))) begin
      fin_rec = cap_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q       <= scan_d;
    hit_q        <= hit_d;
    hit_idx_q    <= hit_idx_d;
    cap_q        <= cap_d;
    res_status_q <= res_status_d;
    if (in_fire) begin
      op_q        <= prl_pkg::op_e'(s_axis_tuser);
      pos_q       <= POS_W'(s_axis_tdata[6:0]);
      key_q.name0 <= s_axis_tdata[70:7];
      key_q.name1 <= s_axis_tdata[134:71];
      key_q.name2 <= s_axis_tdata[166:135];
      key_q.id    <= s_axis_tdata[198:167];
      key_q.mark  <= s_axis_tdata[230:199];
    end
    if ((state_q == ST_FIN) && out_free) begin
      out_user_q <= fin_status;
      out_data_q <= {3'b000, fin_rec.mark, fin_rec.id, fin_rec.name2,
                     fin_rec.name1, fin_rec.name0, 7'(count_q), fin_idx};
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ----- rtl/prl_cell.sv -----
// prl_cell: one slot of the record row; shifts up, down or rotates with
// its neighbors. Depends on prl_pkg.
`timescale 1ns / 1ps

module prl_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned POS_W = 7
) (
  input  logic                 clk_i,
  input  prl_pkg::cell_ctrl_t  ctrl_i,
  input  logic [POS_W-1:0]     pos_i,
  input  prl_pkg::record_t     left_i,
  input  prl_pkg::record_t     right_i,
  output prl_pkg::record_t     rec_o
);

  localparam logic [POS_W-1:0] MyIdx = POS_W'(INDEX);

  prl_pkg::record_t rec_q, rec_d;

  always_comb begin
    rec_d = rec_q;
    unique case (ctrl_i.cmd)
      prl_pkg::CELL_INSERT: begin
        if (MyIdx > pos_i) begin
          rec_d = left_i;
        end else if (MyIdx == pos_i) begin
          rec_d = ctrl_i.wr_rec;
        end
      end
      prl_pkg::CELL_DELETE: begin
        if (MyIdx >= pos_i) begin
          rec_d = right_i;
        end
      end
      prl_pkg::CELL_ROTATE: rec_d = right_i;
      default:              rec_d = rec_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

// ----- rtl/prl_match.sv -----
// prl_match: byte-wise name compare with zero-terminator semantics.
// Depends on prl_pkg.
`timescale 1ns / 1ps

module prl_match #(
  parameter int unsigned NAME_BYTES = prl_pkg::DEF_NAME_BYTES
) (
  input  prl_pkg::record_t stored_i,
  input  prl_pkg::record_t key_i,
  output logic             match_o
);

  logic [159:0] a_vec, b_vec;

  assign a_vec = {stored_i.name2, stored_i.name1, stored_i.name0};
  assign b_vec = {key_i.name2, key_i.name1, key_i.name0};

  // compare stops at the first mismatch or at the stored terminator
  always_comb begin
    logic alive;
    logic m;
    alive = 1'b1;
    m     = 1'b1;
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (alive) begin
        if (a_vec[8*k +: 8] != b_vec[8*k +: 8]) begin
          m     = 1'b0;
          alive = 1'b0;
        end else if (a_vec[8*k +: 8] == 8'd0) begin
          alive = 1'b0;
        end
      end
    end
    match_o = m;
  end

endmodule
